// File: hw/rtl/ldac_pkg.sv
// shared types, constants and root table for the log domain audio compressor
`timescale 1ns / 1ps
package ldac_pkg;

	localparam int CHANNELS = 8;
	localparam int CH_W = $clog2(CHANNELS);
	localparam int ENV_W = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 17;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SLOPE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAKEUP = 3'd4;

	localparam logic signed [24:0] FLOOR_LEVEL_FINE = -25'sd11796480;
	localparam logic signed [27:0] DB_PER_LOG2_Q16 = 28'sd101008905;
	localparam logic signed [22:0] LOG2_PER_DB_Q24 = 23'sd2786635;

	typedef struct packed {
		logic signed [23:0] audio_sample;
		logic [2:0] channel;
	} in_t;

	typedef struct packed {
		logic signed [23:0] out_sample;
		logic [2:0] out_channel;
	} out_t;

	typedef struct packed {
		logic en;
		logic [CH_W-1:0] addr;
		logic signed [ENV_W-1:0] data;
	} env_wr_t;

	typedef logic [16:0][31:0] root_tab_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] vv;
		r = '0;
		b = 64'd1 << 62;
		vv = v;
		for (int i = 0; i < 32; i++) begin
			if (vv >= r + b) begin
				vv = vv - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// roots 2^(2^-k) in unsigned q2.30
	function automatic root_tab_t build_roots();
		root_tab_t rr;
		rr = '0;
		rr[0] = 32'h8000_0000;
		for (int k = 1; k <= 16; k++) begin
			rr[k] = 32'(isqrt64(64'(rr[k-1]) << 30));
		end
		return rr;
	endfunction

	localparam root_tab_t ROOT_TAB = build_roots();

endpackage

// File: hw/rtl/log_domain_audio_compressor.sv
// top level of the log domain feed-forward audio compressor
// one transaction at a time: in_stall holds off input until the result is loaded,
//   after the 16 log squaring rounds, the 16 root product rounds and the serial
//   gain steps; a stalled output also holds the sequencer in its final state
// reset: configuration and control registers take their defaults, every channel envelope reads 0 db
//   through valid bits cleared at once, no clearing pass
`timescale 1ns / 1ps
module log_domain_audio_compressor (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input ldac_pkg::in_t in_data,
	output logic out_valid,
	input logic out_stall,
	output ldac_pkg::out_t out_data,
	input logic cfg_we,
	input logic [ldac_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [ldac_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ldac_pkg::*;

	// sequencer states
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_LOG = 4'd1;
	localparam logic [3:0] ST_LVL = 4'd2;
	localparam logic [3:0] ST_SCL = 4'd3;
	localparam logic [3:0] ST_EMUL = 4'd4;
	localparam logic [3:0] ST_EWB = 4'd5;
	localparam logic [3:0] ST_RDIF = 4'd6;
	localparam logic [3:0] ST_RMUL = 4'd7;
	localparam logic [3:0] ST_GAIN = 4'd8;
	localparam logic [3:0] ST_GMUL = 4'd9;
	localparam logic [3:0] ST_GCLP = 4'd10;
	localparam logic [3:0] ST_ROOT = 4'd11;
	localparam logic [3:0] ST_PROD = 4'd12;
	localparam logic [3:0] ST_FIN = 4'd13;

	// configuration registers
	logic [15:0] attack_q;
	logic [15:0] release_q;
	logic signed [16:0] thresh_q;
	logic signed [16:0] slope_q;
	logic signed [14:0] makeup_q;

	logic [3:0] state_q;
	logic [3:0] cnt_q;

	// per-transaction working registers
	logic signed [23:0] x_q;
	logic [2:0] ch_q;
	logic [23:0] m_q;
	logic [30:0] y_q;
	logic [4:0] lead_q;
	logic [15:0] frac_q;
	logic signed [ENV_W-1:0] env_q;
	logic signed [49:0] lprod_q;
	logic signed [24:0] s_q;
	logic signed [33:0] diff_q;
	logic [15:0] coef_q;
	logic signed [50:0] eprod_q;
	logic gt_q;
	logic signed [33:0] over_q;
	logic signed [50:0] rprod_q;
	logic signed [25:0] g_q;
	logic signed [48:0] gprod_q;
	logic signed [6:0] ip_q;
	logic [15:0] fr_q;
	logic [31:0] f_q;
	logic [55:0] p_q;

	logic out_valid_q;
	out_t out_q;

	logic accept;
	logic out_free;
	logic signed [ENV_W-1:0] env_rd;
	env_wr_t env_wr;

	// input side: normalize magnitude for the log rounds
	logic [23:0] mag_in;
	logic [4:0] lead_in;

	// combinational helpers per state
	logic [61:0] sq;
	logic [31:0] sq_hi;
	logic signed [21:0] l2;
	logic signed [49:0] lvl_rnd;
	logic signed [24:0] s_new;
	logic signed [50:0] e_rnd;
	logic signed [ENV_W-1:0] env_new;
	logic signed [24:0] t256;
	logic signed [50:0] red;
	logic signed [50:0] g_full;
	logic signed [48:0] g2_full;
	logic signed [22:0] g2;
	logic [4:0] root_idx;
	logic [63:0] root_prod;
	logic [5:0] sh;
	logic [63:0] round_sum;
	logic [63:0] mag_full;
	logic [24:0] mag_sat;
	logic signed [23:0] res;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	ldac_env_ram u_env_ram (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(accept),
		.rd_addr(in_data.channel[CH_W-1:0]),
		.rd_data(env_rd),
		.wr(env_wr)
	);

	always_comb begin
		mag_in = in_data.audio_sample[23] ? 24'(-in_data.audio_sample)
			: in_data.audio_sample;
		lead_in = '0;
		for (int i = 1; i < 24; i++) begin
			if (mag_in[i]) begin
				lead_in = 5'(i);
			end
		end
	end

	// one log round: square, renormalize, emit a fraction bit
	assign sq = 62'(y_q) * 62'(y_q);
	assign sq_hi = sq[61:30];

	// log2 to 1/256 db
	assign l2 = {6'(lead_q) - 6'd23, frac_q};
	assign lvl_rnd = (lprod_q + 50'sd2147483648) >>> 32;
	assign s_new = (m_q == '0) ? FLOOR_LEVEL_FINE : {lvl_rnd[16:0], 8'b0};

	// envelope smoothing writeback
	assign e_rnd = (eprod_q + 51'sd32768) >>> 16;
	assign env_new = 32'(e_rnd + 51'(s_q));
	assign env_wr.en = (state_q == ST_EWB);
	assign env_wr.addr = ch_q[CH_W-1:0];
	assign env_wr.data = env_new;

	// gain computer
	assign t256 = {thresh_q, 8'b0};
	assign red = gt_q ? ((rprod_q + 51'sd32768) >>> 16) : '0;
	assign g_full = 51'($signed({makeup_q, 8'b0})) - red;
	assign g2_full = (gprod_q + 49'sd8388608) >>> 24;

	always_comb begin
		if (g2_full < -49'sd2097152) begin
			g2 = -23'sd2097152;
		end else if (g2_full > 49'sd1572864) begin
			g2 = 23'sd1572864;
		end else begin
			g2 = 23'(g2_full);
		end
	end

	// fractional power of two, one root constant per round
	assign root_idx = 5'(cnt_q) + 5'd1;
	assign root_prod = ((64'(f_q) * 64'(ROOT_TAB[root_idx])) + 64'd536870912) >> 30;

	// final scale, round and saturate
	assign sh = 6'(7'sd30 - ip_q);
	assign round_sum = 64'(p_q) + (64'd1 << (sh - 6'd1));
	assign mag_full = (ip_q >= 7'sd24) ? ((m_q != '0) ? 64'd16777216 : 64'd0)
		: (round_sum >> sh);

	always_comb begin
		if (x_q[23]) begin
			mag_sat = (mag_full > 64'd8388608) ? 25'd8388608 : 25'(mag_full);
			res = 24'(-mag_sat);
		end else begin
			mag_sat = (mag_full > 64'd8388607) ? 25'd8388607 : 25'(mag_full);
			res = 24'(mag_sat);
		end
	end

	// configuration writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q <= 16'd65399;
			release_q <= 16'd65522;
			thresh_q <= -17'sd5120;
			slope_q <= 17'sd49152;
			makeup_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ATTACK: attack_q <= cfg_data[15:0];
				REG_RELEASE: release_q <= cfg_data[15:0];
				REG_THRESHOLD: thresh_q <= cfg_data;
				REG_SLOPE: slope_q <= cfg_data;
				REG_MAKEUP: makeup_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// the final state loads a new result itself
			if (out_valid_q && !out_stall && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						state_q <= ST_LOG;
					end
				end
				ST_LOG: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						state_q <= ST_LVL;
					end
				end
				ST_LVL: state_q <= ST_SCL;
				ST_SCL: state_q <= ST_EMUL;
				ST_EMUL: state_q <= ST_EWB;
				ST_EWB: state_q <= ST_RDIF;
				ST_RDIF: state_q <= ST_RMUL;
				ST_RMUL: state_q <= ST_GAIN;
				ST_GAIN: state_q <= ST_GMUL;
				ST_GMUL: state_q <= ST_GCLP;
				ST_GCLP: begin
					cnt_q <= '0;
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						state_q <= ST_PROD;
					end
				end
				ST_PROD: state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					x_q <= in_data.audio_sample;
					ch_q <= in_data.channel;
					m_q <= mag_in;
					lead_q <= lead_in;
					y_q <= 31'(mag_in) << (5'd30 - lead_in);
					frac_q <= '0;
				end
			end
			ST_LOG: begin
				// envelope read data is ready in the first round
				if (cnt_q == 4'd0) begin
					env_q <= env_rd;
				end
				if (sq_hi[31]) begin
					y_q <= sq_hi[31:1];
					frac_q[4'd15 - cnt_q] <= 1'b1;
				end else begin
					y_q <= sq_hi[30:0];
				end
			end
			ST_LVL: lprod_q <= 50'(l2) * 50'(DB_PER_LOG2_Q16);
			ST_SCL: begin
				s_q <= s_new;
				diff_q <= 34'(env_q) - 34'(s_new);
				coef_q <= (s_new > env_q) ? attack_q : release_q;
			end
			ST_EMUL: eprod_q <= 51'($signed({1'b0, coef_q})) * 51'(diff_q);
			ST_EWB: env_q <= env_new;
			ST_RDIF: begin
				gt_q <= env_q > t256;
				over_q <= 34'(env_q) - 34'(t256);
			end
			ST_RMUL: rprod_q <= 51'(over_q) * 51'(slope_q);
			ST_GAIN: begin
				// clamp keeps the log2 gain clamp unchanged
				if (g_full < -51'sd33554432) begin
					g_q <= -26'sd33554432;
				end else if (g_full > 51'sd33554431) begin
					g_q <= 26'sd33554431;
				end else begin
					g_q <= 26'(g_full);
				end
			end
			ST_GMUL: gprod_q <= 49'(g_q) * 49'(LOG2_PER_DB_Q24);
			ST_GCLP: begin
				ip_q <= g2[22:16];
				fr_q <= g2[15:0];
				f_q <= 32'h4000_0000;
			end
			ST_ROOT: begin
				if (fr_q[4'd15 - cnt_q]) begin
					f_q <= root_prod[31:0];
				end
			end
			ST_PROD: p_q <= 56'(m_q) * 56'(f_q);
			ST_FIN: begin
				if (out_free) begin
					out_q.out_sample <= res;
					out_q.out_channel <= ch_q;
				end
			end
			default: ;
		endcase
	end

endmodule

// File: hw/rtl/ldac_env_ram.sv
// per-channel envelope memory with reset valid bits
`timescale 1ns / 1ps
module ldac_env_ram (
	input logic clk,
	input logic arst_n,
	input logic rd_en,
	input logic [ldac_pkg::CH_W-1:0] rd_addr,
	output logic signed [ldac_pkg::ENV_W-1:0] rd_data,
	input ldac_pkg::env_wr_t wr
);
	import ldac_pkg::*;

	logic signed [ENV_W-1:0] mem [CHANNELS];
	logic [CHANNELS-1:0] vld_q;
	logic signed [ENV_W-1:0] rd_q;
	logic rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	// never-written entries read as zero db
	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

// File: tb/ldac_checker.sv
// gain predictor and result checker for the log domain audio compressor
`timescale 1ns / 1ps
module ldac_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input ldac_pkg::in_t in_data,
	input logic out_valid,
	input logic out_stall,
	input ldac_pkg::out_t out_data,
	input logic cfg_we,
	input logic [ldac_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [ldac_pkg::CFG_DATA_W-1:0] cfg_data,
	output int pending,
	output int errors
);
	import ldac_pkg::*;

	longint unsigned pow_roots [17];
	longint attack_c, release_c, thresh, slope, makeup;
	longint env [CHANNELS];
	out_t expected_q [$];

	function automatic longint rnd(input longint v, input int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic longint unsigned sqrt_u64(input longint unsigned v);
		longint unsigned r;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= v)
				r = r | (64'd1 << b);
		end
		return r;
	endfunction

	function automatic longint level_steps(input longint unsigned m);
		int e;
		longint unsigned y;
		longint l2;
		if (m == 0)
			return FLOOR_LEVEL_FINE / 256;
		e = 0;
		while (e < 23 && (m >> (e + 1)) != 0)
			e++;
		y = m << (30 - e);
		l2 = longint'(e - 23) * 65536;
		for (int i = 0; i < 16; i++) begin
			y = (y * y) >> 30;
			if (y >= (64'd1 << 31)) begin
				y = y >> 1;
				l2 += longint'(1) << (15 - i);
			end
		end
		return rnd(l2 * 101008905, 32);
	endfunction

	// updates the channel envelope and returns the processed sample
	function automatic out_t compress(input in_t t);
		longint x, s, e, c, red, g, g2, ip, fr;
		longint unsigned m, f, p, mag;
		out_t r;
		x = longint'(t.audio_sample);
		m = (x < 0) ? -x : x;
		s = level_steps(m) * 256;
		e = env[t.channel];
		c = (s > e) ? attack_c : release_c;
		e = s + rnd(c * (e - s), 16);
		env[t.channel] = e;
		red = 0;
		if (e > thresh * 256)
			red = rnd((e - thresh * 256) * slope, 16);
		g = makeup * 256 - red;
		g2 = rnd(g * 2786635, 24);
		if (g2 < -32 * 65536) g2 = -32 * 65536;
		if (g2 > 24 * 65536) g2 = 24 * 65536;
		ip = g2 >>> 16;
		fr = g2 - ip * 65536;
		f = 64'd1 << 30;
		for (int k = 1; k <= 16; k++) begin
			if ((fr >> (16 - k)) & 1)
				f = (f * pow_roots[k] + (64'd1 << 29)) >> 30;
		end
		p = m * f;
		if (ip >= 24)
			mag = (m != 0) ? (64'd1 << 24) : 0;
		else
			mag = (p + (64'd1 << (29 - ip))) >> (30 - ip);
		if (x < 0) begin
			if (mag > 8388608) mag = 8388608;
			r.out_sample = 24'(-longint'(mag));
		end else begin
			if (mag > 8388607) mag = 8388607;
			r.out_sample = 24'(mag);
		end
		r.out_channel = t.channel;
		return r;
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	initial begin
		errors = 0;
		pow_roots[0] = 64'd1 << 31;
		for (int k = 1; k <= 16; k++)
			pow_roots[k] = sqrt_u64(pow_roots[k-1] << 30);
	end

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			attack_c = 65399;
			release_c = 65522;
			thresh = -5120;
			slope = 49152;
			makeup = 0;
			foreach (env[i]) env[i] = 0;
			expected_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ATTACK: attack_c = cfg_data[15:0];
					REG_RELEASE: release_c = cfg_data[15:0];
					REG_THRESHOLD: thresh = longint'($signed(cfg_data[16:0]));
					REG_SLOPE: slope = longint'($signed(cfg_data[16:0]));
					REG_MAKEUP: makeup = longint'($signed(cfg_data[14:0]));
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_q.push_back(compress(in_data));
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					report("unexpected transaction", out_data.out_sample, 0);
				end else begin
					want = expected_q.pop_front();
					if (out_data.out_sample !== want.out_sample)
						report("out_sample", out_data.out_sample, want.out_sample);
					if (out_data.out_channel !== want.out_channel)
						report("out_channel", out_data.out_channel, want.out_channel);
				end
			end
		end
	end
endmodule

// File: tb/tb_top.sv
// stimulus, clocking and verdict for the log domain audio compressor
`timescale 1ns / 1ps
module tb_top;
	import ldac_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	in_t in_data = '0;
	logic out_valid;
	logic out_stall = 0;
	out_t out_data;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int pending, errors;
	int tx_idle_pct = 0, rx_stall_pct = 0;
	longint cycles = 0;

	always #4 clk = ~clk;

	log_domain_audio_compressor uut (.*);

	ldac_checker chk (.*);

	// receiver back-pressure, random per cycle
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < rx_stall_pct);

	// watchdog: far above the slowest legal run
	always @(posedge clk) begin
		cycles++;
		if (cycles > 1000000) begin
			$display("Verification failed");
			$finish;
		end
	end

	// one input transaction, with random idle cycles ahead of it
	task automatic push_sample(input logic signed [23:0] smp, input logic [2:0] ch);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		in_data <= '{audio_sample: smp, channel: ch};
		do @(posedge clk); while (in_stall);
	endtask

	// drain every result, then let the pipeline settle
	task automatic settle();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic set_regs(input int atk, input int rel, input int thr, input int slp,
			input int mk);
		int vals [5];
		vals = '{atk, rel, thr, slp, mk};
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= CFG_DATA_W'(vals[i]);
			@(posedge clk);
		end
		cfg_we <= 0;
	endtask

	// random sample: magnitude spread over all octaves, occasional silent samples
	function automatic logic signed [23:0] rand_sample();
		logic [23:0] v;
		v = 24'($urandom);
		if ($urandom_range(19) == 0)
			return '0;
		v = v >> $urandom_range(23);
		return $urandom_range(1) ? -$signed(v) : $signed(v);
	endfunction

	initial begin
		logic signed [23:0] edge_vals [8];
		edge_vals = '{24'sh7fffff, -24'sh800000, 24'sd0, 24'sd1, -24'sd1, 24'sh400000,
				-24'sh3fffff, 24'sh000100};
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: field extremes on every channel at reset settings
		tx_idle_pct = 7;
		rx_stall_pct = 88;
		for (int i = 0; i < 16; i++)
			push_sample(edge_vals[i % 8], 3'(i));
		for (int i = 0; i < 6; i++)
			push_sample(24'sh7fffff, 3'd5);
		settle();

		// settings sweep, random traffic; idle mode changes with the phase
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_regs(0, 65535, -46080, 65535, 12288);
				1: set_regs(65535, 0, 0, -65536, -12288);
				2: set_regs(65399, 65522, -5120, 49152, 0);
				3: set_regs(32768, 40000, 65535, 131071, 16383);
				4: set_regs(60000, 65000, -20000, 32768, 3072);
				default: set_regs(1, 65534, -2560, 65535, 32767);
			endcase
			if (ph == 5) begin
				// unused register index must change nothing
				cfg_we <= 1;
				cfg_index <= 3'd7;
				cfg_data <= '1;
				@(posedge clk);
				cfg_we <= 0;
			end
			tx_idle_pct = (ph < 2) ? 7 : (ph < 4) ? 88 : 0;
			rx_stall_pct = (ph < 2) ? 88 : (ph < 4) ? 7 : 0;
			for (int n = 0; n < 180; n++)
				push_sample(rand_sample(), 3'($urandom_range(7)));
			settle();
		end

		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
